FILE: hw/rtl/rlp_pkg.sv
// Shared types, codes and keyword tables of the RTSP request line parser.
package rlp_pkg;

    localparam int LINE_MAX_BYTES = 4096;
    // Position counter saturates at LINE_MAX_BYTES + 1.
    localparam int LINE_POS_W     = 13;
    localparam int FIELD_W        = 8;
    localparam int STATUS_W       = 3;
    localparam int CODE_W         = 4;

    localparam int KW_COUNT   = 11;
    localparam int KW_MAX_LEN = 13;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_END     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_METHOD_BAD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_URL_BAD    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_VER_BAD    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd5;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd11;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Keyword text, first character in the top byte, zero padded at the end.
    typedef logic [KW_MAX_LEN-1:0][7:0] t_kw_text;

    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        {"DESCRIBE",      40'h0},
        {"ANNOUNCE",      40'h0},
        {"GET_", "PARAMETER"   },
        {"OPTIONS",       48'h0},
        {"PAUSE",         64'h0},
        {"PLAY",          72'h0},
        {"RECORD",        56'h0},
        {"REDIRECT",      40'h0},
        {"SETUP",         64'h0},
        {"SET_", "PARAMETER"   },
        {"TEARDOWN",      40'h0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd8, 4'd13, 4'd7, 4'd5, 4'd4, 4'd6, 4'd8, 4'd5, 4'd13, 4'd8
    };

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [CODE_W-1:0]     method_code;
        logic [FIELD_W-1:0]    method_length;
        logic [LINE_POS_W-1:0] url_start;
        logic [FIELD_W-1:0]    url_length;
        logic [LINE_POS_W-1:0] version_start;
        logic [FIELD_W-1:0]    version_length;
        logic [LINE_POS_W-1:0] line_size;
    } t_result;

endpackage

FILE: hw/rtl/rlp_if.sv
// Valid/ready channel interfaces for input bytes and parse results.
interface rlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_buffer;

    modport source (output valid, output data_byte, output last_in_buffer, input ready);
    modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

interface rlp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rlp_pkg::STATUS_W-1:0]         status;
    logic [rlp_pkg::CODE_W-1:0]           method_code;
    logic [rlp_pkg::FIELD_W-1:0]          method_length;
    logic [rlp_pkg::LINE_POS_W-1:0]       url_start;
    logic [rlp_pkg::FIELD_W-1:0]          url_length;
    logic [rlp_pkg::LINE_POS_W-1:0]       version_start;
    logic [rlp_pkg::FIELD_W-1:0]          version_length;
    logic [rlp_pkg::LINE_POS_W-1:0]       line_size;

    modport source (output valid, output status, output method_code, output method_length,
                    output url_start, output url_length, output version_start,
                    output version_length, output line_size, input ready);
    modport sink   (input valid, input status, input method_code, input method_length,
                    input url_start, input url_length, input version_start,
                    input version_length, input line_size, output ready);
endinterface

FILE: hw/rtl/rtsp_request_line_parser.sv
// Top level of the RTSP request line parser: byte stage, parse logic, result stage.
//
//  channel   dir  handshake      beat payload
//  i_in      in   valid/ready    data_byte, last_in_buffer
//  o_out     out  valid/ready    status, method_code, lengths, offsets, line_size
//  i_cfg_*   in   write enable   max_field_len (8 bits)
//
// One beat per cycle sustained while o_out is not stalled. A byte lands in the
// input register when accepted and is parsed once the result stage has room; if
// it closes a line or ends the buffer, its result is then loaded into the output
// register, which drives o_out.valid.
// Reset is synchronous, active low; max_field_len returns to 254.
// A parsed byte needs room in the result stage, so a stalled o_out holds one
// byte in the input register and then drops i_in.ready.
module rtsp_request_line_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlp_in_if.sink            i_in,
    rlp_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);

    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_GAP1    = 3'd1;
    localparam logic [2:0] PH_URL     = 3'd2;
    localparam logic [2:0] PH_GAP2    = 3'd3;
    localparam logic [2:0] PH_VERSION = 3'd4;
    localparam logic [2:0] PH_TAIL    = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    localparam logic [rlp_pkg::LINE_POS_W-1:0] POS_MAX =
        rlp_pkg::LINE_POS_W'(rlp_pkg::LINE_MAX_BYTES);

    // Configuration
    logic [7:0] r_max_len;

    // Input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parse state
    logic [2:0]                          r_phase, n_phase;
    logic [rlp_pkg::LINE_POS_W-1:0]      r_line_pos, n_line_pos;
    logic [rlp_pkg::FIELD_W-1:0]         r_count, n_count;
    logic [rlp_pkg::KW_COUNT-1:0]        r_mask, n_mask;
    logic [rlp_pkg::FIELD_W-1:0]         r_mlen, n_mlen;
    logic [rlp_pkg::LINE_POS_W-1:0]      r_ustart, n_ustart;
    logic [rlp_pkg::FIELD_W-1:0]         r_ulen, n_ulen;
    logic [rlp_pkg::LINE_POS_W-1:0]      r_vstart, n_vstart;
    logic [rlp_pkg::FIELD_W-1:0]         r_vlen, n_vlen;
    logic [rlp_pkg::STATUS_W-1:0]        r_err, n_err;

    // Result stage
    logic             r_out_valid;
    rlp_pkg::t_result r_res;
    rlp_pkg::t_result n_res;

    logic proc;
    logic res_emit;

    logic [rlp_pkg::KW_COUNT-1:0] kw_mask_next;
    logic [rlp_pkg::CODE_W-1:0]   kw_code;

    logic is_ws, is_lf, is_cr;
    logic fail_req, grow_req, grow_fail, fail_now;
    logic [rlp_pkg::STATUS_W-1:0] fail_code, grow_code, fail_code_now;
    logic [rlp_pkg::FIELD_W-1:0]  grow_base;
    logic [rlp_pkg::STATUS_W-1:0] line_status;

    // A byte is parsed when the result stage has room.
    assign proc       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    assign is_ws = (r_in_byte == rlp_pkg::CH_SP) || (r_in_byte == rlp_pkg::CH_TAB);
    assign is_lf = (r_in_byte == rlp_pkg::CH_LF);
    assign is_cr = (r_in_byte == rlp_pkg::CH_CR);

    // Method matching only advances in the method phase; the code is read at
    // line end, when the mask and method length are already settled.
    rlp_keyword_unit u_kw (
        .i_mask      (r_mask),
        .i_count     (r_count),
        .i_byte      (r_in_byte),
        .i_length    (r_mlen),
        .o_mask_next (kw_mask_next),
        .o_code      (kw_code)
    );

    // Phase walk for one byte.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_mask    = r_mask;
        n_mlen    = r_mlen;
        n_ustart  = r_ustart;
        n_ulen    = r_ulen;
        n_vstart  = r_vstart;
        n_vlen    = r_vlen;
        fail_req  = 1'b0;
        fail_code = rlp_pkg::ST_OK;
        grow_req  = 1'b0;
        grow_code = rlp_pkg::ST_OK;
        grow_base = r_count;

        unique case (r_phase)
            PH_METHOD: begin
                if (is_ws) begin
                    n_mlen  = r_count;
                    n_phase = PH_GAP1;
                end else if (is_lf) begin
                    fail_req  = 1'b1;
                    fail_code = rlp_pkg::ST_METHOD_BAD;
                end else begin
                    n_mask    = kw_mask_next;
                    grow_req  = 1'b1;
                    grow_code = rlp_pkg::ST_METHOD_BAD;
                end
            end
            PH_GAP1: begin
                if (is_lf) begin
                    fail_req  = 1'b1;
                    fail_code = rlp_pkg::ST_URL_BAD;
                end else if (!is_ws) begin
                    n_ustart  = r_line_pos;
                    n_phase   = PH_URL;
                    grow_req  = 1'b1;
                    grow_code = rlp_pkg::ST_URL_BAD;
                    grow_base = '0;
                end
            end
            PH_URL: begin
                if (is_ws) begin
                    n_ulen  = r_count;
                    n_phase = PH_GAP2;
                end else if (is_lf) begin
                    fail_req  = 1'b1;
                    fail_code = rlp_pkg::ST_URL_BAD;
                end else begin
                    grow_req  = 1'b1;
                    grow_code = rlp_pkg::ST_URL_BAD;
                end
            end
            PH_GAP2: begin
                if (is_cr || is_lf) begin
                    n_vstart = r_line_pos;
                    n_vlen   = '0;
                    n_phase  = PH_TAIL;
                end else if (!is_ws) begin
                    n_vstart  = r_line_pos;
                    n_phase   = PH_VERSION;
                    grow_req  = 1'b1;
                    grow_code = rlp_pkg::ST_VER_BAD;
                    grow_base = '0;
                end
            end
            PH_VERSION: begin
                if (is_ws || is_cr || is_lf) begin
                    n_vlen  = r_count;
                    n_phase = PH_TAIL;
                end else begin
                    grow_req  = 1'b1;
                    grow_code = rlp_pkg::ST_VER_BAD;
                end
            end
            default: begin
                // tail and skip: bytes are ignored until line end
            end
        endcase

        // Field growth against the configured limit.
        grow_fail = grow_req && (grow_base >= r_max_len);
        if (grow_req && !grow_fail) begin
            n_count = grow_base + 8'd1;
        end

        fail_now      = fail_req || grow_fail;
        fail_code_now = fail_req ? fail_code : grow_code;
        n_err         = r_err;
        if (fail_now) begin
            if (r_err == rlp_pkg::ST_OK) begin
                n_err = fail_code_now;
            end
            n_phase = PH_SKIP;
        end

        // Byte count saturates one past the line limit.
        n_line_pos = (r_line_pos <= POS_MAX) ? r_line_pos + 1'b1 : r_line_pos;

        line_status = (n_line_pos > POS_MAX) ? rlp_pkg::ST_TOO_LONG : n_err;
    end

    // Result word; a failed line reports only its status, with the method code unknown.
    always_comb begin
        res_emit = is_lf || r_in_last;
        n_res    = '0;
        if (is_lf) begin
            n_res.status = line_status;
        end else begin
            n_res.status = rlp_pkg::ST_NO_END;
        end
        n_res.method_code = rlp_pkg::CODE_UNKNOWN;
        if (n_res.status == rlp_pkg::ST_OK) begin
            n_res.method_code    = kw_code;
            n_res.method_length  = n_mlen;
            n_res.url_start      = n_ustart;
            n_res.url_length     = n_ulen;
            n_res.version_start  = n_vstart;
            n_res.version_length = n_vlen;
            n_res.line_size      = n_line_pos;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 8'd254;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_in_buffer;
        end
    end

    // Parse state; every result restarts the line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && res_emit)) begin
            r_phase    <= PH_METHOD;
            r_line_pos <= '0;
            r_count    <= '0;
            r_mask     <= '1;
            r_mlen     <= '0;
            r_ustart   <= '0;
            r_ulen     <= '0;
            r_vstart   <= '0;
            r_vlen     <= '0;
            r_err      <= rlp_pkg::ST_OK;
        end else if (proc) begin
            r_phase    <= n_phase;
            r_line_pos <= n_line_pos;
            r_count    <= n_count;
            r_mask     <= n_mask;
            r_mlen     <= n_mlen;
            r_ustart   <= n_ustart;
            r_ulen     <= n_ulen;
            r_vstart   <= n_vstart;
            r_vlen     <= n_vlen;
            r_err      <= n_err;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_emit) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_res.status;
    assign o_out.method_code    = r_res.method_code;
    assign o_out.method_length  = r_res.method_length;
    assign o_out.url_start      = r_res.url_start;
    assign o_out.url_length     = r_res.url_length;
    assign o_out.version_start  = r_res.version_start;
    assign o_out.version_length = r_res.version_length;
    assign o_out.line_size      = r_res.line_size;

    // A failed line carries no method code and no size.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != rlp_pkg::ST_OK) |->
            (r_res.method_code == rlp_pkg::CODE_UNKNOWN && r_res.line_size == '0))
        else $error("failed result carries method code or size");

    // The parser restarts after each result.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && res_emit) |=> (r_phase == PH_METHOD && r_line_pos == '0))
        else $error("parser did not restart after result");

    // Byte count never runs past one beyond the line limit.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_pos <= POS_MAX + 1'b1)
        else $error("line position beyond saturation");

    // A good line ends past its url and version offsets.
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status == rlp_pkg::ST_OK) |->
            (r_res.line_size != '0 && r_res.url_start < r_res.line_size
             && r_res.version_start < r_res.line_size))
        else $error("ok result with offsets past line end");

    // No byte is parsed while a result waits without room.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !proc)
        else $error("byte parsed while result stage full");

endmodule

FILE: hw/rtl/rlp_keyword_unit.sv
// Parallel keyword compare for the method field and method code lookup.
module rlp_keyword_unit (
    input  logic [rlp_pkg::KW_COUNT-1:0] i_mask,
    input  logic [rlp_pkg::FIELD_W-1:0]  i_count,
    input  logic [7:0]                   i_byte,
    input  logic [rlp_pkg::FIELD_W-1:0]  i_length,
    output logic [rlp_pkg::KW_COUNT-1:0] o_mask_next,
    output logic [rlp_pkg::CODE_W-1:0]   o_code
);

    logic [3:0] char_idx;

    // Only meaningful while the count is below the keyword length.
    assign char_idx = 4'(rlp_pkg::KW_MAX_LEN - 1) - i_count[3:0];

    always_comb begin
        for (int k = 0; k < rlp_pkg::KW_COUNT; k++) begin
            o_mask_next[k] = i_mask[k]
                && (i_count < {4'b0, rlp_pkg::KW_LEN[k]})
                && (rlp_pkg::KW_TEXT[k][char_idx] == i_byte);
        end
    end

    // Lowest matching keyword wins.
    always_comb begin
        o_code = rlp_pkg::CODE_UNKNOWN;
        for (int k = rlp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (i_mask[k] && (i_length == {4'b0, rlp_pkg::KW_LEN[k]})) begin
                o_code = 4'(k);
            end
        end
    end

endmodule
